// File: hw/rtl/bcle_pkg.sv
// package for the bounded circular list engine
// command and status codes, sequencer states and free pool control
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bcle_pkg;

  localparam logic [2:0] CMD_INS_END   = 3'd0;
  localparam logic [2:0] CMD_INS_FRONT = 3'd1;
  localparam logic [2:0] CMD_INS_POS   = 3'd2;
  localparam logic [2:0] CMD_DEL_FIRST = 3'd3;
  localparam logic [2:0] CMD_DEL_LAST  = 3'd4;
  localparam logic [2:0] CMD_DEL_VALUE = 3'd5;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_BADPOS   = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_WALK   = 6'b000010,
    S_WRITE1 = 6'b000100,
    S_WRITE2 = 6'b001000,
    S_UNLINK = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  typedef struct packed {
    logic pop;
    logic push;
    logic clear;
  } pool_ctl_t;

endpackage
`default_nettype wire

// File: hw/rtl/bcle_free_pool.sv
// free slot pool: bump counter for never used slots plus a stack of released ones
// depends on bcle_pkg
`timescale 1ns / 1ps
`default_nettype none
module bcle_free_pool #(
  parameter int CAPACITY = 16
) (
  input  wire                           clk,
  input  wire                           rst,
  input  bcle_pkg::pool_ctl_t           ctl,
  input  wire  [$clog2(CAPACITY)-1:0]   push_slot,
  output logic [$clog2(CAPACITY)-1:0]   free_slot
);
  import bcle_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [IW-1:0] stk [CAPACITY];
  logic [CW-1:0] sp;
  logic [CW-1:0] fresh;
  logic [IW-1:0] top_q;
  logic [CW-1:0] sp_m1;

  assign sp_m1 = sp - CW'(1);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      sp    <= '0;
      fresh <= '0;
    end else if (ctl.pop) begin
      if (sp != '0) begin
        sp <= sp_m1;
      end else begin
        fresh <= fresh + CW'(1);
      end
    end else if (ctl.push) begin
      sp <= sp + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.clear) begin
      stk[sp[IW-1:0]] <= push_slot;
    end
    top_q <= stk[sp_m1[IW-1:0]];
  end

  // released slots are reused first
  assign free_slot = (sp != '0) ? top_q : fresh[IW-1:0];

endmodule
`default_nettype wire

// File: hw/rtl/bounded_circular_list_engine_core.sv
// circular singly linked list engine, top level
// holds link and value memories and the command sequencer; uses bcle_pkg, bcle_free_pool
//
// usage: one command request enters on s_axis (s_tvalid/s_tready/s_tdata), one result
// leaves on m_axis (m_tvalid/m_tready/m_tdata) for every command.
// a rejected or unused command goes straight to its result; an insert into an empty list
// writes its slot and finishes; other inserts walk to the predecessor, write the new slot
// and relink the predecessor; a delete unlinks its slot once the walk has found it. the
// link memory is read once per cycle while the list is walked, and one write port serves
// all link updates.
// s_tready is high only while the sequencer is idle; one command is in flight.
// the result stays registered on m_axis until it is taken; while the receiver
// stalls no new command is taken.
// reset empties the list at once; memory contents need no clearing since only
// slots held by the list are ever read.
`timescale 1ns / 1ps
`default_nettype none
module bounded_circular_list_engine_core #(
  parameter int CAPACITY = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [39:0] s_tdata,   // cmd[2:0], item_value[34:3], position[39:35]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata    // status[2:0], entries_now[7:3]
);
  import bcle_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = ((CW > 5) ? CW : 5) + 1;

  state_t state;
  logic [2:0]  op;
  logic [31:0] val;
  logic [SW-1:0] steps;
  logic        head;
  logic        make_tail;
  logic [IW-1:0] cur, prev, first, nxt, dslot, nslot, tail;
  logic [CW-1:0] count;
  logic [2:0]  st;

  logic [IW-1:0] link_mem [CAPACITY];
  logic [31:0]   val_mem  [CAPACITY];
  logic [IW-1:0] lq;
  logic [31:0]   vq;
  logic [IW-1:0] ra;

  logic          lwe;
  logic [IW-1:0] lwa, lwd;

  pool_ctl_t     pctl;
  logic [IW-1:0] free_slot;

  logic [2:0]  in_cmd;
  logic [31:0] in_val;
  logic [4:0]  in_pos;
  logic        full;
  logic        bad_pos;
  logic [SW:0] pos_x, cnt_p1;
  logic [CW+4:0] cnt_x;

  assign in_cmd = s_tdata[2:0];
  assign in_val = s_tdata[34:3];
  assign in_pos = s_tdata[39:35];

  assign full    = count >= CW'(CAPACITY);
  assign pos_x   = {{(SW+1-5){1'b0}}, in_pos};
  assign cnt_p1  = {{(SW+1-CW){1'b0}}, count} + (SW+1)'(1);
  assign bad_pos = (count == '0) || (in_pos == 5'd0) || (pos_x > cnt_p1);

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign cnt_x    = {5'b0, count};
  assign m_tdata  = {cnt_x[4:0], st};

  bcle_free_pool #(.CAPACITY(CAPACITY)) u_pool (
    .clk       (clk),
    .rst       (rst),
    .ctl       (pctl),
    .push_slot (dslot),
    .free_slot (free_slot)
  );

  // next walk address follows the link just read
  assign ra = (state == S_WALK) ? lq : tail;

  always_ff @(posedge clk) begin
    lq <= link_mem[ra];
    vq <= val_mem[ra];
    if (lwe) begin
      link_mem[lwa] <= lwd;
    end
    if (state == S_WRITE1) begin
      val_mem[free_slot] <= val;
    end
  end

  always_comb begin
    lwe = 1'b0;
    lwa = prev;
    lwd = nxt;
    pctl = '0;
    case (state)
      S_WRITE1: begin
        lwe = 1'b1;
        lwa = free_slot;
        lwd = (count == '0) ? free_slot : nxt;
        pctl.pop = 1'b1;
      end
      S_WRITE2: begin
        lwe = 1'b1;
        lwd = nslot;
      end
      S_UNLINK: begin
        if (count <= CW'(1)) begin
          pctl.clear = 1'b1;
        end else begin
          lwe = 1'b1;
          pctl.push = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tail  <= '0;
      count <= '0;
      st    <= ST_DONE;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op    <= in_cmd;
            val   <= in_val;
            cur   <= tail;
            prev  <= tail;
            head  <= 1'b1;
            st    <= ST_DONE;
            state <= S_OUT;
            case (in_cmd)
              CMD_INS_END, CMD_INS_FRONT: begin
                if (full) begin
                  st <= ST_FULL;
                end else if (count == '0) begin
                  state <= S_WRITE1;
                end else begin
                  steps <= SW'(1);
                  state <= S_WALK;
                end
              end
              CMD_INS_POS: begin
                if (bad_pos) begin
                  st <= ST_BADPOS;
                end else if (full) begin
                  st <= ST_FULL;
                end else begin
                  steps <= {{(SW-5){1'b0}}, in_pos};
                  state <= S_WALK;
                end
              end
              CMD_DEL_FIRST, CMD_DEL_VALUE: begin
                if (count == '0) begin
                  st <= ST_EMPTY;
                end else begin
                  steps <= {{(SW-CW){1'b0}}, count};
                  state <= S_WALK;
                end
              end
              CMD_DEL_LAST: begin
                if (count == '0) begin
                  st <= ST_EMPTY;
                end else if (count == CW'(1)) begin
                  state <= S_UNLINK;
                end else begin
                  steps <= {{(SW-CW){1'b0}}, count} - SW'(1);
                  state <= S_WALK;
                end
              end
              default: ;
            endcase
          end
        end
        S_WALK: begin
          case (op)
            CMD_INS_END, CMD_INS_FRONT, CMD_INS_POS: begin
              if (steps == SW'(1)) begin
                prev      <= cur;
                nxt       <= lq;
                // position one links after the tail but leaves the tail in place
                make_tail <= (op == CMD_INS_END) ||
                             (op == CMD_INS_POS && !head && cur == tail);
                state     <= S_WRITE1;
              end else begin
                cur   <= lq;
                head  <= 1'b0;
                steps <= steps - SW'(1);
              end
            end
            CMD_DEL_LAST: begin
              head <= 1'b0;
              if (head) begin
                first <= lq;
              end
              if (steps == SW'(1)) begin
                prev  <= lq;
                dslot <= tail;
                nxt   <= head ? lq : first;
                state <= S_UNLINK;
              end else begin
                cur   <= lq;
                steps <= steps - SW'(1);
              end
            end
            default: begin
              // first read only fetches the front entry
              if (head) begin
                cur  <= lq;
                head <= 1'b0;
              end else if (op == CMD_DEL_FIRST || vq == val) begin
                dslot <= cur;
                nxt   <= lq;
                state <= S_UNLINK;
              end else if (steps == SW'(1)) begin
                st    <= ST_NOTFOUND;
                state <= S_OUT;
              end else begin
                prev  <= cur;
                cur   <= lq;
                steps <= steps - SW'(1);
              end
            end
          endcase
        end
        S_WRITE1: begin
          nslot <= free_slot;
          count <= count + CW'(1);
          if (count == '0) begin
            tail  <= free_slot;
            state <= S_OUT;
          end else begin
            state <= S_WRITE2;
          end
        end
        S_WRITE2: begin
          if (make_tail) begin
            tail <= nslot;
          end
          state <= S_OUT;
        end
        S_UNLINK: begin
          if (count <= CW'(1)) begin
            tail  <= '0;
            count <= '0;
          end else begin
            if (dslot == tail) begin
              tail <= prev;
            end
            count <= count - CW'(1);
          end
          st    <= ST_DONE;
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bcle_checker.sv
// port level checks for the circular list engine
// bound to bounded_circular_list_engine_core; no package use
`timescale 1ns / 1ps
`default_nettype none
module bcle_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire [39:0] s_tdata,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [7:0]  m_tdata
);

  // a held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one request in flight: no intake while a result is shown
  a_single: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("ready while result pending");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready right after a request");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= 3'd4)
    else $error("status code out of range");

endmodule

bind bounded_circular_list_engine_core bcle_checker u_bcle_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
